FILE: src/tlca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tlca_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int MAX_EDGES_DEF   = 2048;
    localparam int LIFT_LEVELS_DEF = 11;

    localparam int CMD_W   = 2;
    localparam int FIELD_W = 10;
    localparam int DIST_W  = 12;
    localparam int ST_W    = 2;

    localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_DECODE, S_OUT,
        E_RDA, E_W1, E_W2,
        B_CLR, B_INIT, B_POP, B_U, B_HEAD, B_EDGE, B_TGT, B_CHK,
        B_ANC_RD, B_ANC_WR, B_ROW,
        Q_D0, Q_D1, Q_D2, Q_PAIR, Q_SUM, Q_CMP, Q_FIN,
        L_START, L_UP_RD, L_UP_CMP, L_EQ, L_DN, L_FIN, L_RES, L_RESD
    } state_t;

endpackage
`default_nettype wire

FILE: src/tlca_anc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tlca_anc_ram #(
    parameter int MAX_NODES   = tlca_pkg::MAX_NODES_DEF,
    parameter int LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF,
    parameter int NW          = $clog2(MAX_NODES)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        we,
    input  wire logic [NW-1:0]               waddr,
    input  wire logic [LIFT_LEVELS*NW-1:0]   wrow,
    input  wire logic                        re0,
    input  wire logic [NW-1:0]               raddr0,
    output logic      [LIFT_LEVELS*NW-1:0]   rrow0,
    input  wire logic                        re1,
    input  wire logic [NW-1:0]               raddr1,
    output logic      [LIFT_LEVELS*NW-1:0]   rrow1
);

    logic [LIFT_LEVELS*NW-1:0] mem [MAX_NODES];
    logic [LIFT_LEVELS*NW-1:0] data0_reg, data1_reg;
    logic                      zero0_reg, zero1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wrow;
        end
        if (re0) begin
            data0_reg <= mem[raddr0];
        end
        if (re1) begin
            data1_reg <= mem[raddr1];
        end
    end

    // rows of the null node and of the root are never written and read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero0_reg <= 1'b1;
            zero1_reg <= 1'b1;
        end else begin
            if (re0) begin
                zero0_reg <= (raddr0 < NW'(2));
            end
            if (re1) begin
                zero1_reg <= (raddr1 < NW'(2));
            end
        end
    end

    assign rrow0 = zero0_reg ? '0 : data0_reg;
    assign rrow1 = zero1_reg ? '0 : data1_reg;

endmodule
`default_nettype wire

FILE: src/tree_lca_three_node_meeting_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Tree engine: edge insert, breadth-first build from root node 1, three-node meeting query.
// Input channel s_*: s_tuser carries the command, s_tdata the three nodes.
// Result channel m_*: exactly one transfer per accepted command.
// After reset the head lists and depths are cleared by a pass over all MAX_NODES entries;
// s_tready stays low during that pass.
// Steps per command, one command in flight at a time:
//   edge insert: head list reads, then an edge write and a head write per direction;
//   rejected edge or spare command: straight to the result
//   build: depth clear, then per popped node a queue read and a head and depth read,
//   per edge scanned an edge read and a target depth check, and per newly reached node
//   its ancestor row built level by level; query: 12 ancestor searches, each climbing
//   through every lifting level
// The lifting levels are walked one table read at a time through the two read
// ports of the ancestor row memory; that loop sets the query time.
// A finished result sits in an output register; the next command is taken while
// it waits. If the receiver stalls, the following result waits in its final state
// until the output register frees up, and s_tready stays low meanwhile.
module tree_lca_three_node_meeting_unit #(
    parameter int MAX_NODES   = tlca_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = tlca_pkg::MAX_EDGES_DEF,
    parameter int LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // node_a[9:0], node_b[19:10], node_c[29:20]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // meeting_node[9:0], total_distance[21:10]
    output logic      [1:0]  m_tuser    // status[1:0]
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int DW = NW + 1;
    localparam int EW = $clog2(MAX_EDGES);
    localparam int HW = EW + 1;
    localparam int LW = $clog2(LIFT_LEVELS);
    localparam int SW = DW + 3;
    localparam int RW = LIFT_LEVELS * NW;
    localparam logic [DW-1:0] UNREACHED = '1;

    tlca_pkg::state_t state_reg, state_next;

    logic [tlca_pkg::CMD_W-1:0]   cmd_reg;
    logic [tlca_pkg::FIELD_W-1:0] fa_reg, fb_reg, fc_reg;
    logic [NW-1:0] v_reg [3];
    logic [DW-1:0] dv_reg [3];
    logic [HW-1:0] edge_cnt_reg;
    logic [NW:0]   sweep_reg, hd_reg, tl_reg;
    logic [NW-1:0] u_reg, bv_reg;
    logic [DW-1:0] du_reg;
    logic [HW-1:0] e_reg;
    logic [NW-1:0] row_reg [LIFT_LEVELS];
    logic [LW-1:0] kb_reg, lk_reg;
    logic [NW-1:0] la_reg, lb_reg, lr_reg;
    logic [DW-1:0] lda_reg, ldb_reg;
    logic          ret_reg;
    logic [1:0]    pi_reg, j_reg;
    logic [NW-1:0] o_reg, best_node_reg;
    logic [DW-1:0] do_reg;
    logic [SW-1:0] sum_reg, best_sum_reg;
    logic [NW-1:0] res_node_reg;
    logic [SW-1:0] res_sum_reg;
    logic [tlca_pkg::ST_W-1:0] res_st_reg;
    logic          m_valid_reg;
    logic [23:0]   m_data_reg;
    logic [1:0]    m_user_reg;

    // memories and their ports
    logic [HW-1:0] head_mem [MAX_NODES];
    logic [NW-1:0] tgt_mem  [MAX_EDGES];
    logic [HW-1:0] lnk_mem  [MAX_EDGES];
    logic [DW-1:0] dep_mem  [MAX_NODES];
    logic [NW-1:0] q_mem    [MAX_NODES];

    logic          head_re, head_we;
    logic [NW-1:0] head_raddr, head_waddr;
    logic [HW-1:0] head_wdata, head_rdata_reg;
    logic          edge_re, edge_we;
    logic [EW-1:0] edge_raddr, edge_waddr;
    logic [NW-1:0] tgt_wdata, tgt_rdata_reg;
    logic [HW-1:0] lnk_wdata, lnk_rdata_reg;
    logic          dep_re0, dep_re1, dep_we;
    logic [NW-1:0] dep_raddr0, dep_raddr1, dep_waddr;
    logic [DW-1:0] dep_wdata, dep_rdata0_reg, dep_rdata1_reg;
    logic          q_re, q_we;
    logic [NW-1:0] q_raddr, q_waddr, q_wdata, q_rdata_reg;
    logic          anc_re0, anc_re1, anc_we;
    logic [NW-1:0] anc_raddr0, anc_raddr1, anc_waddr;
    logic [RW-1:0] anc_wrow, anc_rrow0, anc_rrow1;

    function automatic logic in_range(input logic [tlca_pkg::FIELD_W-1:0] f);
        in_range = (f != '0) && (32'(f) < MAX_NODES);
    endfunction

    function automatic logic [NW-1:0] lvl(input logic [RW-1:0] r, input logic [LW-1:0] k);
        lvl = r[k*NW +: NW];
    endfunction

    logic          swap;
    logic [NW-1:0] up_cand, dn_a, dn_b;
    logic [1:0]    px, py;
    logic [SW-1:0] dist_add;
    logic          s_fire, out_free;

    assign swap     = lda_reg < ldb_reg;
    assign up_cand  = lvl(anc_rrow0, lk_reg);
    assign dn_a     = lvl(anc_rrow0, lk_reg);
    assign dn_b     = lvl(anc_rrow1, lk_reg);
    assign px       = (pi_reg == 2'd2) ? 2'd1 : 2'd0;
    assign py       = (pi_reg == 2'd0) ? 2'd1 : 2'd2;
    assign dist_add = SW'(dv_reg[j_reg]) + SW'(do_reg) - (SW'(dep_rdata0_reg) << 1);
    assign s_tready = (state_reg == tlca_pkg::S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tlca_pkg::S_CLR: begin
                if (sweep_reg == (NW+1)'(MAX_NODES - 1)) state_next = tlca_pkg::S_IDLE;
            end
            tlca_pkg::S_IDLE: begin
                if (s_fire) state_next = tlca_pkg::S_DECODE;
            end
            tlca_pkg::S_DECODE: begin
                case (cmd_reg)
                    tlca_pkg::CMD_EDGE: begin
                        if (!in_range(fa_reg) || !in_range(fb_reg)) begin
                            state_next = tlca_pkg::S_OUT;
                        end else if (32'(edge_cnt_reg) + 32'd2 > MAX_EDGES) begin
                            state_next = tlca_pkg::S_OUT;
                        end else begin
                            state_next = tlca_pkg::E_RDA;
                        end
                    end
                    tlca_pkg::CMD_BUILD: state_next = tlca_pkg::B_CLR;
                    tlca_pkg::CMD_QUERY: begin
                        if (!in_range(fa_reg) || !in_range(fb_reg) || !in_range(fc_reg)) begin
                            state_next = tlca_pkg::S_OUT;
                        end else begin
                            state_next = tlca_pkg::Q_D0;
                        end
                    end
                    default: state_next = tlca_pkg::S_OUT;
                endcase
            end
            tlca_pkg::S_OUT: begin
                if (out_free) state_next = tlca_pkg::S_IDLE;
            end
            tlca_pkg::E_RDA: state_next = tlca_pkg::E_W1;
            tlca_pkg::E_W1:  state_next = tlca_pkg::E_W2;
            tlca_pkg::E_W2:  state_next = tlca_pkg::S_OUT;
            tlca_pkg::B_CLR: begin
                if (sweep_reg == (NW+1)'(MAX_NODES - 1)) state_next = tlca_pkg::B_INIT;
            end
            tlca_pkg::B_INIT: state_next = tlca_pkg::B_POP;
            tlca_pkg::B_POP: begin
                if (hd_reg < tl_reg && 32'(hd_reg) < MAX_NODES) state_next = tlca_pkg::B_U;
                else state_next = tlca_pkg::S_OUT;
            end
            tlca_pkg::B_U:    state_next = tlca_pkg::B_HEAD;
            tlca_pkg::B_HEAD: state_next = tlca_pkg::B_EDGE;
            tlca_pkg::B_EDGE: begin
                if (e_reg == '0) state_next = tlca_pkg::B_POP;
                else state_next = tlca_pkg::B_TGT;
            end
            tlca_pkg::B_TGT: state_next = tlca_pkg::B_CHK;
            tlca_pkg::B_CHK: begin
                if ({1'b0, dep_rdata0_reg} > ({1'b0, du_reg} + 1'b1)) begin
                    state_next = tlca_pkg::B_ANC_RD;
                end else begin
                    state_next = tlca_pkg::B_EDGE;
                end
            end
            tlca_pkg::B_ANC_RD: state_next = tlca_pkg::B_ANC_WR;
            tlca_pkg::B_ANC_WR: begin
                if (kb_reg == LW'(LIFT_LEVELS - 1)) state_next = tlca_pkg::B_ROW;
                else state_next = tlca_pkg::B_ANC_RD;
            end
            tlca_pkg::B_ROW: state_next = tlca_pkg::B_EDGE;
            tlca_pkg::Q_D0:  state_next = tlca_pkg::Q_D1;
            tlca_pkg::Q_D1:  state_next = tlca_pkg::Q_D2;
            tlca_pkg::Q_D2: begin
                if (dep_rdata0_reg == UNREACHED || dv_reg[0] == UNREACHED ||
                    dv_reg[1] == UNREACHED) begin
                    state_next = tlca_pkg::S_OUT;
                end else begin
                    state_next = tlca_pkg::Q_PAIR;
                end
            end
            tlca_pkg::Q_PAIR: state_next = tlca_pkg::L_START;
            tlca_pkg::Q_SUM:  state_next = tlca_pkg::L_START;
            tlca_pkg::Q_CMP: begin
                if (pi_reg == 2'd2) state_next = tlca_pkg::Q_FIN;
                else state_next = tlca_pkg::Q_PAIR;
            end
            tlca_pkg::Q_FIN:   state_next = tlca_pkg::S_OUT;
            tlca_pkg::L_START: state_next = tlca_pkg::L_UP_RD;
            tlca_pkg::L_UP_RD: state_next = tlca_pkg::L_UP_CMP;
            tlca_pkg::L_UP_CMP: begin
                if (lk_reg == '0) state_next = tlca_pkg::L_EQ;
                else state_next = tlca_pkg::L_UP_RD;
            end
            tlca_pkg::L_EQ: begin
                if (la_reg == lb_reg) state_next = tlca_pkg::L_RES;
                else state_next = tlca_pkg::L_DN;
            end
            tlca_pkg::L_DN: begin
                if (lk_reg == '0) state_next = tlca_pkg::L_FIN;
            end
            tlca_pkg::L_FIN: state_next = tlca_pkg::L_RES;
            tlca_pkg::L_RES: state_next = tlca_pkg::L_RESD;
            tlca_pkg::L_RESD: begin
                if (!ret_reg) state_next = tlca_pkg::Q_SUM;
                else if (j_reg == 2'd2) state_next = tlca_pkg::Q_CMP;
                else state_next = tlca_pkg::Q_SUM;
            end
            default: state_next = tlca_pkg::S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        head_re = 1'b0; head_raddr = '0; head_we = 1'b0; head_waddr = '0; head_wdata = '0;
        edge_re = 1'b0; edge_raddr = '0; edge_we = 1'b0; edge_waddr = '0;
        tgt_wdata = '0; lnk_wdata = '0;
        dep_re0 = 1'b0; dep_raddr0 = '0; dep_re1 = 1'b0; dep_raddr1 = '0;
        dep_we = 1'b0; dep_waddr = '0; dep_wdata = '0;
        q_re = 1'b0; q_raddr = '0; q_we = 1'b0; q_waddr = '0; q_wdata = '0;
        anc_re0 = 1'b0; anc_raddr0 = '0; anc_re1 = 1'b0; anc_raddr1 = '0;
        anc_we = 1'b0; anc_waddr = '0; anc_wrow = '0;
        unique case (state_reg)
            tlca_pkg::S_CLR: begin
                head_we = 1'b1; head_waddr = sweep_reg[NW-1:0]; head_wdata = '0;
                dep_we = 1'b1; dep_waddr = sweep_reg[NW-1:0]; dep_wdata = UNREACHED;
            end
            tlca_pkg::E_RDA: begin
                head_re = 1'b1; head_raddr = v_reg[0];
            end
            tlca_pkg::E_W1: begin
                edge_we = 1'b1; edge_waddr = edge_cnt_reg[EW-1:0];
                tgt_wdata = v_reg[1]; lnk_wdata = head_rdata_reg;
                head_we = 1'b1; head_waddr = v_reg[0]; head_wdata = edge_cnt_reg + 1'b1;
                head_re = 1'b1; head_raddr = v_reg[1];
            end
            tlca_pkg::E_W2: begin
                edge_we = 1'b1; edge_waddr = EW'(edge_cnt_reg + 1'b1);
                tgt_wdata = v_reg[0];
                // self loop: the head just written is not yet visible at the read port
                lnk_wdata = (v_reg[0] == v_reg[1]) ? edge_cnt_reg + 1'b1 : head_rdata_reg;
                head_we = 1'b1; head_waddr = v_reg[1]; head_wdata = edge_cnt_reg + HW'(2);
            end
            tlca_pkg::B_CLR: begin
                dep_we = 1'b1; dep_waddr = sweep_reg[NW-1:0];
                if (sweep_reg == '0) dep_wdata = '0;
                else if (sweep_reg == (NW+1)'(1)) dep_wdata = DW'(1);
                else dep_wdata = UNREACHED;
            end
            tlca_pkg::B_INIT: begin
                q_we = 1'b1; q_waddr = '0; q_wdata = NW'(1);
            end
            tlca_pkg::B_POP: begin
                q_re = 1'b1; q_raddr = hd_reg[NW-1:0];
            end
            tlca_pkg::B_U: begin
                head_re = 1'b1; head_raddr = q_rdata_reg;
                dep_re0 = 1'b1; dep_raddr0 = q_rdata_reg;
            end
            tlca_pkg::B_EDGE: begin
                edge_re = 1'b1; edge_raddr = EW'(e_reg - 1'b1);
            end
            tlca_pkg::B_TGT: begin
                dep_re0 = 1'b1; dep_raddr0 = tgt_rdata_reg;
            end
            tlca_pkg::B_CHK: begin
                if ({1'b0, dep_rdata0_reg} > ({1'b0, du_reg} + 1'b1)) begin
                    dep_we = 1'b1; dep_waddr = bv_reg; dep_wdata = du_reg + 1'b1;
                    if (32'(tl_reg) < MAX_NODES) begin
                        q_we = 1'b1; q_waddr = tl_reg[NW-1:0]; q_wdata = bv_reg;
                    end
                end
            end
            tlca_pkg::B_ANC_RD: begin
                anc_re0 = 1'b1; anc_raddr0 = row_reg[kb_reg - 1'b1];
            end
            tlca_pkg::B_ROW: begin
                anc_we = 1'b1; anc_waddr = bv_reg;
                for (int i = 0; i < LIFT_LEVELS; i++) anc_wrow[i*NW +: NW] = row_reg[i];
            end
            tlca_pkg::Q_D0: begin
                dep_re0 = 1'b1; dep_raddr0 = v_reg[0];
                dep_re1 = 1'b1; dep_raddr1 = v_reg[1];
            end
            tlca_pkg::Q_D1: begin
                dep_re0 = 1'b1; dep_raddr0 = v_reg[2];
            end
            tlca_pkg::L_START: begin
                anc_re0 = 1'b1; anc_raddr0 = swap ? lb_reg : la_reg;
                anc_re1 = 1'b1; anc_raddr1 = swap ? la_reg : lb_reg;
            end
            tlca_pkg::L_UP_RD: begin
                dep_re0 = 1'b1; dep_raddr0 = up_cand;
            end
            tlca_pkg::L_UP_CMP: begin
                if (dep_rdata0_reg >= ldb_reg) begin
                    anc_re0 = 1'b1; anc_raddr0 = up_cand;
                end
            end
            tlca_pkg::L_DN: begin
                if (dn_a != dn_b) begin
                    anc_re0 = 1'b1; anc_raddr0 = dn_a;
                    anc_re1 = 1'b1; anc_raddr1 = dn_b;
                end
            end
            tlca_pkg::L_RES: begin
                dep_re0 = 1'b1; dep_raddr0 = lr_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_waddr] <= head_wdata;
        if (head_re) head_rdata_reg <= head_mem[head_raddr];
        if (edge_we) begin
            tgt_mem[edge_waddr] <= tgt_wdata;
            lnk_mem[edge_waddr] <= lnk_wdata;
        end
        if (edge_re) begin
            tgt_rdata_reg <= tgt_mem[edge_raddr];
            lnk_rdata_reg <= lnk_mem[edge_raddr];
        end
        if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
        if (dep_re0) dep_rdata0_reg <= dep_mem[dep_raddr0];
        if (dep_re1) dep_rdata1_reg <= dep_mem[dep_raddr1];
        if (q_we) q_mem[q_waddr] <= q_wdata;
        if (q_re) q_rdata_reg <= q_mem[q_raddr];
    end

    tlca_anc_ram #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS),
        .NW          (NW)
    ) u_anc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (anc_we),
        .waddr   (anc_waddr),
        .wrow    (anc_wrow),
        .re0     (anc_re0),
        .raddr0  (anc_raddr0),
        .rrow0   (anc_rrow0),
        .re1     (anc_re1),
        .raddr1  (anc_raddr1),
        .rrow1   (anc_rrow1)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tlca_pkg::S_CLR;
            sweep_reg    <= '0;
            edge_cnt_reg <= '0;
            hd_reg       <= '0;
            tl_reg       <= '0;
            lk_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tlca_pkg::S_CLR || state_reg == tlca_pkg::B_CLR) begin
                sweep_reg <= sweep_reg + 1'b1;
            end else begin
                sweep_reg <= '0;
            end
            if (state_reg == tlca_pkg::E_W2) edge_cnt_reg <= edge_cnt_reg + HW'(2);
            case (state_reg)
                tlca_pkg::B_INIT: begin
                    hd_reg <= '0;
                    tl_reg <= (NW+1)'(1);
                end
                tlca_pkg::B_POP: begin
                    if (state_next == tlca_pkg::B_U) hd_reg <= hd_reg + 1'b1;
                end
                tlca_pkg::B_CHK: begin
                    if (state_next == tlca_pkg::B_ANC_RD && 32'(tl_reg) < MAX_NODES) begin
                        tl_reg <= tl_reg + 1'b1;
                    end
                end
                tlca_pkg::L_START: lk_reg <= LW'(LIFT_LEVELS - 1);
                tlca_pkg::L_UP_CMP: begin
                    if (lk_reg != '0) lk_reg <= lk_reg - 1'b1;
                end
                tlca_pkg::L_EQ: lk_reg <= LW'(LIFT_LEVELS - 1);
                tlca_pkg::L_DN: begin
                    if (lk_reg != '0) lk_reg <= lk_reg - 1'b1;
                end
                default: ;
            endcase
            if (state_reg == tlca_pkg::S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= s_tuser;
            fa_reg  <= s_tdata[9:0];
            fb_reg  <= s_tdata[19:10];
            fc_reg  <= s_tdata[29:20];
        end
        if (state_reg == tlca_pkg::S_OUT && out_free) begin
            m_data_reg <= {2'b00, tlca_pkg::DIST_W'(res_sum_reg),
                           tlca_pkg::FIELD_W'(res_node_reg)};
            m_user_reg <= res_st_reg;
        end
        case (state_reg)
            tlca_pkg::S_DECODE: begin
                v_reg[0]     <= NW'(fa_reg);
                v_reg[1]     <= NW'(fb_reg);
                v_reg[2]     <= NW'(fc_reg);
                res_node_reg <= '0;
                res_sum_reg  <= '0;
                if (cmd_reg == tlca_pkg::CMD_EDGE &&
                    (!in_range(fa_reg) || !in_range(fb_reg))) begin
                    res_st_reg <= tlca_pkg::ST_BAD;
                end else if (cmd_reg == tlca_pkg::CMD_EDGE &&
                             32'(edge_cnt_reg) + 32'd2 > MAX_EDGES) begin
                    res_st_reg <= tlca_pkg::ST_FULL;
                end else if (cmd_reg == tlca_pkg::CMD_QUERY &&
                             (!in_range(fa_reg) || !in_range(fb_reg) ||
                              !in_range(fc_reg))) begin
                    res_st_reg <= tlca_pkg::ST_BAD;
                end else begin
                    res_st_reg <= tlca_pkg::ST_OK;
                end
            end
            tlca_pkg::B_U: u_reg <= q_rdata_reg;
            tlca_pkg::B_HEAD: begin
                e_reg  <= head_rdata_reg;
                du_reg <= dep_rdata0_reg;
            end
            tlca_pkg::B_TGT: bv_reg <= tgt_rdata_reg;
            tlca_pkg::B_CHK: begin
                if (state_next == tlca_pkg::B_ANC_RD) begin
                    row_reg[0] <= u_reg;
                    kb_reg     <= LW'(1);
                end else begin
                    e_reg <= lnk_rdata_reg;
                end
            end
            tlca_pkg::B_ANC_WR: begin
                row_reg[kb_reg] <= lvl(anc_rrow0, kb_reg - 1'b1);
                if (kb_reg != LW'(LIFT_LEVELS - 1)) kb_reg <= kb_reg + 1'b1;
            end
            tlca_pkg::B_ROW: e_reg <= lnk_rdata_reg;
            tlca_pkg::Q_D1: begin
                dv_reg[0] <= dep_rdata0_reg;
                dv_reg[1] <= dep_rdata1_reg;
            end
            tlca_pkg::Q_D2: begin
                dv_reg[2] <= dep_rdata0_reg;
                pi_reg    <= '0;
                if (state_next == tlca_pkg::S_OUT) res_st_reg <= tlca_pkg::ST_BAD;
            end
            tlca_pkg::Q_PAIR: begin
                la_reg  <= v_reg[px];
                lda_reg <= dv_reg[px];
                lb_reg  <= v_reg[py];
                ldb_reg <= dv_reg[py];
                ret_reg <= 1'b0;
            end
            tlca_pkg::Q_SUM: begin
                la_reg  <= v_reg[j_reg];
                lda_reg <= dv_reg[j_reg];
                lb_reg  <= o_reg;
                ldb_reg <= do_reg;
                ret_reg <= 1'b1;
            end
            tlca_pkg::Q_CMP: begin
                if (pi_reg == 2'd0 || sum_reg < best_sum_reg) begin
                    best_sum_reg  <= sum_reg;
                    best_node_reg <= o_reg;
                end
                pi_reg <= pi_reg + 1'b1;
            end
            tlca_pkg::Q_FIN: begin
                res_node_reg <= best_node_reg;
                res_sum_reg  <= best_sum_reg;
                res_st_reg   <= tlca_pkg::ST_OK;
            end
            tlca_pkg::L_START: begin
                // deeper node climbs
                if (swap) begin
                    la_reg  <= lb_reg;
                    lb_reg  <= la_reg;
                    ldb_reg <= lda_reg;
                end
            end
            tlca_pkg::L_UP_CMP: begin
                if (dep_rdata0_reg >= ldb_reg) la_reg <= up_cand;
            end
            tlca_pkg::L_EQ: lr_reg <= la_reg;
            tlca_pkg::L_DN: begin
                if (dn_a != dn_b) begin
                    la_reg <= dn_a;
                    lb_reg <= dn_b;
                end
            end
            tlca_pkg::L_FIN: lr_reg <= lvl(anc_rrow0, '0);
            tlca_pkg::L_RESD: begin
                if (!ret_reg) begin
                    o_reg   <= lr_reg;
                    do_reg  <= dep_rdata0_reg;
                    j_reg   <= '0;
                    sum_reg <= '0;
                end else begin
                    sum_reg <= sum_reg + dist_add;
                    if (j_reg != 2'd2) j_reg <= j_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_edge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(edge_cnt_reg) <= MAX_EDGES)
        else $error("edge count beyond store size");

    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        hd_reg <= tl_reg)
        else $error("walk queue head passed tail");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(lk_reg) < LIFT_LEVELS)
        else $error("lifting level out of range");

    a_lca_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tlca_pkg::L_START |->
            $past(state_reg) == tlca_pkg::Q_PAIR || $past(state_reg) == tlca_pkg::Q_SUM)
        else $error("ancestor search started outside a query");

endmodule
`default_nettype wire

FILE: bench/tree_lca_three_node_meeting_unit_tb.sv
`timescale 1ns / 1ps
module tree_lca_three_node_meeting_unit_tb;

    localparam int NODES     = tlca_pkg::MAX_NODES_DEF;
    localparam int EDGES     = tlca_pkg::MAX_EDGES_DEF;
    localparam int LEVELS    = tlca_pkg::LIFT_LEVELS_DEF;
    localparam int UNREACHED = 'h7FF;
    localparam int LIMIT     = 2000000;
    localparam logic [tlca_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [tlca_pkg::FIELD_W-1:0] meet;
        logic [tlca_pkg::DIST_W-1:0]  total;
        logic [tlca_pkg::ST_W-1:0]    status;
    } meet_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    tree_lca_three_node_meeting_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow copy of the tree store
    int unsigned head_of[NODES];
    int unsigned edge_to[EDGES];
    int unsigned edge_next[EDGES];
    int unsigned edge_total;
    int unsigned depth_of[NODES];
    int unsigned lift[NODES][LEVELS];
    int unsigned bfs_fifo[NODES];

    meet_result_t pending_results[$];
    int  fail_count = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  stall_req = 1'b0;
    int  stall_left = 0;

    // labels already hooked to the root, and labels in use
    int unsigned linked[$];
    bit          taken[NODES];

    function automatic void push_entry(int unsigned from, int unsigned to);
        edge_to[edge_total] = to;
        edge_next[edge_total] = head_of[from];
        head_of[from] = edge_total + 1;
        edge_total++;
    endfunction

    function automatic void walk_tree();
        int unsigned hd, tl, u, e, v;
        hd = 0;
        tl = 0;
        for (int k = 0; k < NODES; k++) depth_of[k] = UNREACHED;
        depth_of[0] = 0;
        depth_of[1] = 1;
        bfs_fifo[tl++] = 1;
        while (hd < tl && hd < NODES) begin
            u = bfs_fifo[hd++];
            e = head_of[u];
            while (e != 0 && e <= EDGES) begin
                v = edge_to[e-1] % NODES;
                if (depth_of[v] > depth_of[u] + 1) begin
                    depth_of[v] = depth_of[u] + 1;
                    if (tl < NODES) bfs_fifo[tl++] = v;
                    lift[v][0] = u;
                    for (int k = 1; k < LEVELS; k++) lift[v][k] = lift[lift[v][k-1]][k-1];
                end
                e = edge_next[e-1];
            end
        end
    endfunction

    function automatic int unsigned common_root(int unsigned a, int unsigned b);
        int unsigned t;
        if (depth_of[a] < depth_of[b]) begin
            t = a; a = b; b = t;
        end
        for (int k = LEVELS - 1; k >= 0; k--)
            if (depth_of[lift[a][k]] >= depth_of[b]) a = lift[a][k];
        if (a == b) return a;
        for (int k = LEVELS - 1; k >= 0; k--)
            if (lift[a][k] != lift[b][k]) begin
                a = lift[a][k];
                b = lift[b][k];
            end
        return lift[a][0];
    endfunction

    function automatic bit node_usable(int unsigned n);
        return n != 0 && depth_of[n] != UNREACHED;
    endfunction

    function automatic meet_result_t run_command(logic [1:0] cmd, int unsigned a,
                                                 int unsigned b, int unsigned c);
        meet_result_t r;
        int unsigned v[3], o, sum;
        bit have;
        r = '0;
        v[0] = a; v[1] = b; v[2] = c;
        have = 1'b0;
        case (cmd)
            tlca_pkg::CMD_EDGE: begin
                if (a == 0 || b == 0) r.status = tlca_pkg::ST_BAD;
                else if (edge_total + 2 > EDGES) r.status = tlca_pkg::ST_FULL;
                else begin
                    push_entry(a, b);
                    push_entry(b, a);
                end
            end
            tlca_pkg::CMD_BUILD: walk_tree();
            tlca_pkg::CMD_QUERY: begin
                if (!node_usable(a) || !node_usable(b) || !node_usable(c))
                    r.status = tlca_pkg::ST_BAD;
                else begin
                    for (int p = 0; p < 3; p++)
                        for (int q = p + 1; q < 3; q++) begin
                            o = common_root(v[p], v[q]);
                            sum = 0;
                            for (int j = 0; j < 3; j++)
                                sum += depth_of[v[j]] + depth_of[o]
                                       - 2 * depth_of[common_root(v[j], o)];
                            if (!have || sum < r.total) begin
                                have = 1'b1;
                                r.total = sum;
                                r.meet = o;
                            end
                        end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send(logic [1:0] cmd, int unsigned a, int unsigned b, int unsigned c);
        while (!quiet && $urandom_range(99) < 20) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser  = cmd;
        s_tdata  = {2'b00, c[9:0], b[9:0], a[9:0]};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // the block sees only the low ten bits of each node
        pending_results.push_back(run_command(cmd, a & 32'h3FF, b & 32'h3FF, c & 32'h3FF));
        @(negedge aclk);
    endtask

    function automatic int unsigned fresh_label();
        int unsigned n;
        do n = $urandom_range(NODES - 1, 2); while (taken[n]);
        taken[n] = 1'b1;
        return n;
    endfunction

    function automatic int unsigned pick_linked();
        return linked[$urandom_range(linked.size() - 1)];
    endfunction

    task automatic test_directed();
        // queries and edge checks before any build
        send(tlca_pkg::CMD_QUERY, 1, 1, 1);
        send(tlca_pkg::CMD_EDGE, 0, 5, 0);
        send(tlca_pkg::CMD_EDGE, 5, 0, 0);
        send(CMD_SPARE, 1023, 1023, 1023);
        send(tlca_pkg::CMD_EDGE, 1, 2, 0);
        send(tlca_pkg::CMD_EDGE, 1, 3, 0);
        send(tlca_pkg::CMD_EDGE, 2, 4, 0);
        send(tlca_pkg::CMD_EDGE, 2, 5, 0);
        send(tlca_pkg::CMD_EDGE, 3, 1023, 0);
        send(tlca_pkg::CMD_EDGE, 1023, 512, 0);
        send(tlca_pkg::CMD_EDGE, 4, 2, 0);      // duplicate, not a tree edge
        send(tlca_pkg::CMD_EDGE, 5, 1023, 0);   // cross link, first visitor wins
        send(tlca_pkg::CMD_BUILD, 0, 0, 0);
        send(tlca_pkg::CMD_QUERY, 4, 5, 1023);
        send(tlca_pkg::CMD_QUERY, 512, 4, 1);
        send(tlca_pkg::CMD_QUERY, 1, 1, 1);
        send(tlca_pkg::CMD_QUERY, 0, 4, 5);
        send(tlca_pkg::CMD_QUERY, 4, 700, 5);
        send(tlca_pkg::CMD_EDGE, 5, 6, 0);
        send(tlca_pkg::CMD_QUERY, 6, 4, 5);     // unreached until rebuilt
        send(tlca_pkg::CMD_BUILD, 1023, 1023, 1023);
        send(tlca_pkg::CMD_QUERY, 6, 512, 4);
        send(CMD_SPARE, 0, 0, 0);
        foreach (taken[i]) taken[i] = (i <= 6 || i == 512 || i == 1023);
        linked = {1, 2, 3, 4, 5, 6, 512, 1023};
    endtask

    task automatic test_random_trees();
        int unsigned n, p, stray;
        for (int round = 0; round < 3; round++) begin
            quiet = (round == 1);
            repeat ($urandom_range(100, 60)) begin
                case ($urandom_range(9))
                    0: send(2'($urandom_range(3)), $urandom, $urandom, $urandom);
                    1: send(tlca_pkg::CMD_EDGE, pick_linked(), pick_linked(), $urandom);
                    2: begin
                        stray = fresh_label();
                        send(tlca_pkg::CMD_EDGE, stray, fresh_label(), $urandom);
                    end
                    default: begin
                        // mostly chains for depth, else a random parent
                        p = ($urandom_range(1)) ? linked[linked.size() - 1] : pick_linked();
                        n = fresh_label();
                        send(tlca_pkg::CMD_EDGE, ($urandom_range(1)) ? p : n,
                             ($urandom_range(1)) ? n : p, $urandom);
                        if (p != n) linked.push_back(n);
                    end
                endcase
            end
            send(tlca_pkg::CMD_BUILD, $urandom, $urandom, $urandom);
            repeat ($urandom_range(90, 70)) begin
                if ($urandom_range(9) == 0)
                    send(tlca_pkg::CMD_QUERY, $urandom, pick_linked(), $urandom);
                else
                    send(tlca_pkg::CMD_QUERY, pick_linked(), pick_linked(), pick_linked());
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_output_stall();
        stall_req = 1'b1;
        repeat (20) send(tlca_pkg::CMD_QUERY, pick_linked(), pick_linked(), pick_linked());
    endtask

    task automatic test_late_edges();
        repeat (30) send(tlca_pkg::CMD_EDGE, pick_linked(), pick_linked(), 0);
        send(tlca_pkg::CMD_EDGE, 0, pick_linked(), 0);
        send(tlca_pkg::CMD_EDGE, 1023, 1023, 1023);
        send(tlca_pkg::CMD_BUILD, 0, 0, 0);
        repeat (15) send(tlca_pkg::CMD_QUERY, pick_linked(), pick_linked(), pick_linked());
    endtask

    always @(negedge aclk) begin
        if (stall_req) begin
            stall_req = 1'b0;
            stall_left = 3000;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = quiet || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge aclk) begin
        meet_result_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[9:0] !== want.meet) begin
                    $error("meeting_node expected %0d actual %0d", want.meet, m_tdata[9:0]);
                    fail_count++;
                end
                if (m_tdata[21:10] !== want.total) begin
                    $error("total_distance expected %0d actual %0d", want.total,
                           m_tdata[21:10]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NODES; i++) begin
            head_of[i] = 0;
            depth_of[i] = UNREACHED;
            for (int k = 0; k < LEVELS; k++) lift[i][k] = 0;
        end
        edge_total = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random_trees();
        test_output_stall();
        test_late_edges();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
